FILE: hw/rtl/trm_pkg.sv
// shared types and constants of the three-phase rms monitor
package trm_pkg;

	localparam int unsigned MAX_SAMPLES  = 4096;
	localparam int unsigned CNT_W        = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned MIN_SAMPLES  = 20;
	localparam int unsigned SUM_W        = 28;
	localparam int unsigned SQ_W         = 43;
	localparam int unsigned DVD_W        = 56;
	localparam int unsigned DVS_W        = 25;
	localparam int unsigned QUO_W        = 31;
	localparam int unsigned ROOT_W       = 16;
	localparam logic [15:0] LEVEL_MAX    = 16'hFFFF;
	localparam logic [14:0] IMB_MAX      = 15'd20000;
	localparam logic [17:0] MEAN_FLOOR_X3 = 18'd30;
	localparam logic [13:0] IMB_SCALE    = 14'd10000;

	typedef enum logic [3:0] {
		REG_SAMPLE_INTERVAL = 4'd0,
		REG_WINDOW_LENGTH   = 4'd1,
		REG_SCALE_A         = 4'd2,
		REG_SCALE_B         = 4'd3,
		REG_SCALE_C         = 4'd4,
		REG_LOSS_LEVEL      = 4'd5,
		REG_UNDER_LEVEL     = 4'd6,
		REG_OVER_LEVEL      = 4'd7
	} trm_reg_t;

	typedef enum logic [1:0] {
		COND_NORMAL = 2'd0,
		COND_LOST   = 2'd1,
		COND_UNDER  = 2'd2,
		COND_OVER   = 2'd3
	} trm_cond_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIFF,
		S_DIV_WAIT,
		S_SQRT_WAIT,
		S_LVL,
		S_IMB,
		S_IMB_DIV,
		S_IMB_WAIT,
		S_DONE
	} trm_state_t;

	typedef struct packed {
		logic               start;
		logic [DVD_W-1:0]   dividend;
		logic [DVS_W-1:0]   divisor;
	} trm_div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [QUO_W-1:0]   quotient;
	} trm_div_rsp_t;

	typedef struct packed {
		logic               start;
		logic [QUO_W-1:0]   radicand;
	} trm_sqrt_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [ROOT_W-1:0]  root;
	} trm_sqrt_rsp_t;

endpackage

FILE: hw/rtl/three_phase_rms_monitor_core.sv
// three-phase rms monitor: window accumulation, sequencer and result register
// an item that closes no window is taken in idle and the input stall stays low
// a closing item gives its result at the end of the close computation, sooner with no imbalance
// each phase runs the products, the difference, the divider, the square root and the level, in order
// throughput: one item per cycle between closes, input stalled during the close and result stall
// reset: registers take their documented defaults, sums, counts and window state clear
module three_phase_rms_monitor_core (
	input  logic               clk,
	input  logic               arst_n,
	// input item channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        now_ms,
	input  logic signed [15:0] sample_a,
	input  logic signed [15:0] sample_b,
	input  logic signed [15:0] sample_c,
	// result item channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        level_a,
	output logic [15:0]        level_b,
	output logic [15:0]        level_c,
	output logic [1:0]         cond_a,
	output logic [1:0]         cond_b,
	output logic [1:0]         cond_c,
	output logic [14:0]        imbalance,
	output logic               imbalance_valid,
	// configuration writes
	input  logic               cfg_write,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import trm_pkg::*;

	// configuration registers
	logic [15:0] interval_q;
	logic [31:0] window_len_q;
	logic [31:0] scale_q [3];
	logic [15:0] loss_q;
	logic [15:0] under_q;
	logic [15:0] over_q;

	// window state
	logic [31:0]             last_time_q;
	logic [31:0]             start_time_q;
	logic                    open_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic [SQ_W-1:0]         sq_q [3];

	// sequencer and working registers
	trm_state_t       state_q, state_d;
	logic [1:0]       k_q;
	logic [DVD_W-1:0] s2_q;
	logic [DVD_W-1:0] nsq_q;
	logic [DVS_W-1:0] nn_q;
	logic [47:0]      prod_q;
	logic [15:0]      lvl_q [3];
	logic [17:0]      total_q;
	logic [17:0]      maxdev_q;
	logic             imb_ok_q;
	logic [14:0]      imb_q;

	// result register
	logic        out_valid_q;
	logic [15:0] out_lvl_q [3];
	logic [1:0]  out_cond_q [3];
	logic [14:0] out_imb_q;
	logic        out_imb_ok_q;

	trm_div_req_t  div_req;
	trm_div_rsp_t  div_rsp;
	trm_sqrt_req_t sqrt_req;
	trm_sqrt_rsp_t sqrt_rsp;

	trm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	trm_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	// ---------------------------------------------------------------
	// intake: interval gate, accumulate, decide on window close
	// ---------------------------------------------------------------
	logic                    accept;
	logic                    take;
	logic [31:0]             since_last;
	logic [31:0]             win_start;
	logic [31:0]             elapsed;
	logic [CNT_W-1:0]        cnt_new;
	logic                    close;
	logic signed [15:0]      smp [3];

	assign accept     = in_valid && !in_stall;
	assign since_last = now_ms - last_time_q;
	assign take       = accept && (since_last >= {16'd0, interval_q});
	// a sample that opens the window starts it at its own time
	assign win_start  = open_q ? start_time_q : now_ms;
	assign elapsed    = now_ms - win_start;
	assign cnt_new    = cnt_q + 1'b1;
	assign close      = ((elapsed >= window_len_q) && (cnt_new >= CNT_W'(MIN_SAMPLES)))
		|| (cnt_new >= CNT_W'(MAX_SAMPLES));

	assign smp[0] = sample_a;
	assign smp[1] = sample_b;
	assign smp[2] = sample_c;

	// ---------------------------------------------------------------
	// per-phase arithmetic for the phase under work
	// ---------------------------------------------------------------
	logic signed [SUM_W-1:0] cur_sum;
	logic [SUM_W-1:0]        mag;
	logic [DVD_W-1:0]        var_num;
	logic [31:0]             scaled;
	logic [15:0]             lvl_sat;

	assign cur_sum = sum_q[k_q];
	assign mag     = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
	// negative variance from rounding folds to zero
	assign var_num = (nsq_q > s2_q) ? (nsq_q - s2_q) : '0;
	assign scaled  = prod_q[47:16];
	assign lvl_sat = (scaled[31:16] != 16'd0) ? LEVEL_MAX : scaled[15:0];

	// ---------------------------------------------------------------
	// imbalance: largest |3*L - S| over the three levels
	// ---------------------------------------------------------------
	logic [17:0] total;
	logic [17:0] t3 [3];
	logic [17:0] dev [3];
	logic [17:0] maxdev;
	logic        any_lost;

	always_comb begin
		total    = 18'(lvl_q[0]) + 18'(lvl_q[1]) + 18'(lvl_q[2]);
		maxdev   = '0;
		any_lost = 1'b0;
		for (int i = 0; i < 3; i++) begin
			t3[i]  = 18'(lvl_q[i]) + 18'({lvl_q[i], 1'b0});
			dev[i] = (t3[i] > total) ? (t3[i] - total) : (total - t3[i]);
			if (dev[i] > maxdev) begin
				maxdev = dev[i];
			end
			if (lvl_q[i] < loss_q) begin
				any_lost = 1'b1;
			end
		end
	end

	logic [31:0] imb_num;
	logic [14:0] imb_sat;

	assign imb_num = maxdev_q * IMB_SCALE;
	assign imb_sat = (div_rsp.quotient > QUO_W'(IMB_MAX)) ? IMB_MAX
		: div_rsp.quotient[14:0];

	// result may load once the output register is free or being drained
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d           = state_q;
		in_stall          = 1'b1;
		div_req.start     = 1'b0;
		div_req.dividend  = var_num;
		div_req.divisor   = nn_q;
		sqrt_req.start    = 1'b0;
		sqrt_req.radicand = div_rsp.quotient;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (take && close) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_DIFF;
			end
			S_DIFF: begin
				div_req.start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					sqrt_req.start = 1'b1;
					state_d        = S_SQRT_WAIT;
				end
			end
			S_SQRT_WAIT: begin
				if (sqrt_rsp.done) begin
					state_d = S_LVL;
				end
			end
			S_LVL: begin
				state_d = (k_q == 2'd2) ? S_IMB : S_MUL;
			end
			S_IMB: begin
				state_d = (!any_lost && (total > MEAN_FLOOR_X3)) ? S_IMB_DIV : S_DONE;
			end
			S_IMB_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(imb_num);
				div_req.divisor  = DVS_W'(total_q);
				state_d          = S_IMB_WAIT;
			end
			S_IMB_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// configuration and window state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= 16'd2;
			window_len_q <= 32'd1000;
			scale_q[0]   <= 32'd819;
			scale_q[1]   <= 32'd819;
			scale_q[2]   <= 32'd819;
			loss_q       <= 16'd5000;
			under_q      <= 16'd20700;
			over_q       <= 16'd25300;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SAMPLE_INTERVAL: interval_q   <= cfg_data[15:0];
				REG_WINDOW_LENGTH:   window_len_q <= cfg_data;
				REG_SCALE_A:         scale_q[0]   <= cfg_data;
				REG_SCALE_B:         scale_q[1]   <= cfg_data;
				REG_SCALE_C:         scale_q[2]   <= cfg_data;
				REG_LOSS_LEVEL:      loss_q       <= cfg_data[15:0];
				REG_UNDER_LEVEL:     under_q      <= cfg_data[15:0];
				REG_OVER_LEVEL:      over_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q  <= '0;
			start_time_q <= '0;
			open_q       <= 1'b0;
			cnt_q        <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
		end else if (take) begin
			last_time_q <= now_ms;
			open_q      <= 1'b1;
			cnt_q       <= cnt_new;
			// a closing sample starts the next window at its own time
			start_time_q <= close ? now_ms : win_start;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= sum_q[i] + SUM_W'(smp[i]);
				sq_q[i]  <= sq_q[i] + SQ_W'($unsigned(32'(smp[i]) * 32'(smp[i])));
			end
		end else if ((state_q == S_DONE) && out_free) begin
			// window results are out, start the new window empty
			cnt_q <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				sq_q[i]  <= '0;
			end
		end
	end

	// ---------------------------------------------------------------
	// working registers of the close computation
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (state_q == S_IDLE) begin
			k_q <= '0;
		end else if (state_q == S_LVL) begin
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_MUL: begin
				s2_q  <= mag * mag;
				nsq_q <= DVD_W'(cnt_q) * DVD_W'(sq_q[k_q]);
				nn_q  <= DVS_W'(cnt_q) * DVS_W'(cnt_q);
			end
			S_SQRT_WAIT: begin
				prod_q <= sqrt_rsp.root * scale_q[k_q];
			end
			S_LVL: begin
				lvl_q[k_q] <= lvl_sat;
			end
			S_IMB: begin
				total_q  <= total;
				maxdev_q <= maxdev;
				imb_ok_q <= !any_lost && (total > MEAN_FLOOR_X3);
				imb_q    <= '0;
			end
			S_IMB_WAIT: begin
				if (div_rsp.done) begin
					imb_q <= imb_sat;
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			for (int i = 0; i < 3; i++) begin
				out_lvl_q[i] <= lvl_q[i];
				priority if (lvl_q[i] < loss_q) begin
					out_cond_q[i] <= COND_LOST;
				end else if (lvl_q[i] < under_q) begin
					out_cond_q[i] <= COND_UNDER;
				end else if (lvl_q[i] > over_q) begin
					out_cond_q[i] <= COND_OVER;
				end else begin
					out_cond_q[i] <= COND_NORMAL;
				end
			end
			out_imb_q    <= imb_q;
			out_imb_ok_q <= imb_ok_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign level_a         = out_lvl_q[0];
	assign level_b         = out_lvl_q[1];
	assign level_c         = out_lvl_q[2];
	assign cond_a          = out_cond_q[0];
	assign cond_b          = out_cond_q[1];
	assign cond_c          = out_cond_q[2];
	assign imbalance       = out_imb_q;
	assign imbalance_valid = out_imb_ok_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_imb_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !imbalance_valid) |-> (imbalance == 15'd0))
		else $error("imbalance nonzero while marked invalid");

	a_imb_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (imbalance <= IMB_MAX))
		else $error("imbalance above its ceiling");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("window sample count past its limit");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> ((state_q == S_DIV_WAIT) || (state_q == S_IMB_WAIT)))
		else $error("divider finished outside a wait state");

endmodule

FILE: hw/rtl/trm_divider.sv
// iterative restoring divider, one quotient bit per cycle
module trm_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trm_pkg::trm_div_req_t req,
	output trm_pkg::trm_div_rsp_t rsp
);
	import trm_pkg::*;

	localparam int unsigned STEP_W = $clog2(QUO_W);

	logic [DVD_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= DVD_W'({req.divisor, {(QUO_W-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: hw/rtl/trm_isqrt.sv
// iterative integer square root, one result bit per cycle
module trm_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  trm_pkg::trm_sqrt_req_t req,
	output trm_pkg::trm_sqrt_rsp_t rsp
);
	import trm_pkg::*;

	localparam int unsigned STEP_W = $clog2(ROOT_W);
	localparam int unsigned ACC_W  = QUO_W + 1;

	logic [QUO_W-1:0]  v_q;
	logic [ACC_W-1:0]  res_q;
	logic [ACC_W-1:0]  bit_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ACC_W-1:0]  trial;
	logic              fits;

	assign trial = res_q + bit_q;
	assign fits  = ({1'b0, v_q} >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q   <= req.radicand;
			res_q <= '0;
			bit_q <= ACC_W'(1) << (2 * (ROOT_W - 1));
		end else if (busy_q) begin
			if (fits) begin
				v_q   <= QUO_W'({1'b0, v_q} - trial);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = res_q[ROOT_W-1:0];

endmodule
